>>> sv/psd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// psd_pkg
// Shared types and constants of the PGM/PPM stream decoder: result kinds,
// error codes, header limits and the command word between front and back.
// ----------------------------------------------------------------------------
package psd_pkg;

  // Result kinds
  localparam logic [1:0] KIND_HEADER = 2'd0;
  localparam logic [1:0] KIND_PIXEL  = 2'd1;
  localparam logic [1:0] KIND_ERROR  = 2'd2;

  // Error codes
  localparam logic [2:0] ERR_NONE      = 3'd0;
  localparam logic [2:0] ERR_MAGIC     = 3'd1;
  localparam logic [2:0] ERR_NUMBER    = 3'd2;
  localparam logic [2:0] ERR_SIZE      = 3'd3;
  localparam logic [2:0] ERR_AREA      = 3'd4;
  localparam logic [2:0] ERR_TRUNCATED = 3'd5;

  // Field and state widths
  localparam int SIDE_W  = 15;
  localparam int ACC_W   = 17;
  localparam int PROD_W  = 21;
  localparam int AREA_W  = 29;
  localparam int MPIX_W  = 9;

  // Command queue size
  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = 2;

  // Header limits
  localparam logic [SIDE_W-1:0] MAX_SIDE    = 15'd16384;
  localparam logic [SIDE_W-1:0] SIDE_OVER   = 15'd16385;
  localparam logic [PROD_W-1:0] NUM_LIMIT   = 21'd100000;
  localparam logic [ACC_W-1:0]  MAXVAL_REQ  = 17'd255;
  localparam logic [AREA_W-1:0] MEGA        = 29'd1000000;
  localparam logic [MPIX_W-1:0] MPIX_RESET  = 9'd40;

  // Characters of the header syntax
  localparam logic [7:0] CH_P    = 8'h50;
  localparam logic [7:0] CH_5    = 8'h35;
  localparam logic [7:0] CH_6    = 8'h36;
  localparam logic [7:0] CH_HASH = 8'h23;
  localparam logic [7:0] CH_0    = 8'h30;
  localparam logic [7:0] CH_9    = 8'h39;
  localparam logic [7:0] CH_SP   = 8'h20;
  localparam logic [7:0] CH_TAB  = 8'h09;
  localparam logic [7:0] CH_LF   = 8'h0A;
  localparam logic [7:0] CH_CR   = 8'h0D;

  // Command operations from front to back
  typedef enum logic [1:0] {
    OP_HEADER = 2'd0,
    OP_SAMPLE = 2'd1,
    OP_ERROR  = 2'd2
  } op_t;

  // Role of a payload sample
  typedef enum logic [1:0] {
    ROLE_RED   = 2'd0,
    ROLE_GREEN = 2'd1,
    ROLE_FINAL = 2'd2
  } role_t;

  typedef struct packed {
    op_t               op;
    role_t             role;
    logic [7:0]        sample;
    logic [SIDE_W-1:0] width;
    logic [SIDE_W-1:0] height;
    logic              gray;
    logic              last;
    logic [2:0]        err;
  } cmd_t;

  // Queue status seen by front and back
  typedef struct packed {
    logic empty;
    logic full;
  } q_stat_t;

endpackage : psd_pkg
`default_nettype wire

>>> sv/psd_ifs.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// psd channel interfaces
// Valid/ready channels of the decoder: file bytes in, results out, and the
// area limit register write.
// ----------------------------------------------------------------------------
interface psd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_file;

  modport source (output valid, output data_byte, output end_of_file, input ready);
  modport sink   (input valid, input data_byte, input end_of_file, output ready);
endinterface : psd_in_if

interface psd_out_if;
  logic                        valid;
  logic                        ready;
  logic [1:0]                  kind;
  logic [psd_pkg::SIDE_W-1:0]  image_width;
  logic [psd_pkg::SIDE_W-1:0]  image_height;
  logic                        is_gray;
  logic [7:0]                  blue;
  logic [7:0]                  green;
  logic [7:0]                  red;
  logic                        last_pixel;
  logic [2:0]                  error_code;

  modport source (output valid, output kind, output image_width, output image_height,
                  output is_gray, output blue, output green, output red,
                  output last_pixel, output error_code, input ready);
  modport sink   (input valid, input kind, input image_width, input image_height,
                  input is_gray, input blue, input green, input red,
                  input last_pixel, input error_code, output ready);
endinterface : psd_out_if

interface psd_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [psd_pkg::MPIX_W-1:0]  max_megapixels;

  modport source (output valid, output max_megapixels, input ready);
  modport sink   (input valid, input max_megapixels, output ready);
endinterface : psd_cfg_if
`default_nettype wire

>>> sv/ppm_stream_decoder.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ppm_stream_decoder
// Byte-stream decoder for binary PGM (P5) and PPM (P6) images.
// ----------------------------------------------------------------------------
// Feed the file one byte per transfer on in_ch, with end_of_file on its last
// byte. The block accepts one byte every cycle: each byte is parsed by the
// front parser as it is accepted and, when it yields something, placed in
// a four-entry command queue; the result stage assembles BGR pixels and
// holds each result in an output register, so in_ch stalls only when the
// queue fills behind a stalled out_ch. Results are a header record (width,
// height, gray flag), one pixel per gray byte or per RGB byte triple, or an
// error code; a result passes through the queue and then the output register
// before it is offered on out_ch.
// The area limit on cfg_ch (megapixels, reset 40) is to be written by the user
// only while idle; the block itself does not enforce it.
// ----------------------------------------------------------------------------
module ppm_stream_decoder (
  input  wire logic clk,
  input  wire logic rst_n,
  psd_in_if.sink    in_ch,
  psd_out_if.source out_ch,
  psd_cfg_if.sink   cfg_ch
);
  import psd_pkg::*;

  logic     q_push;
  cmd_t     q_push_cmd;
  logic     q_pop;
  cmd_t     q_head_cmd;
  q_stat_t  q_stat;

  psd_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .cfg_ch (cfg_ch),
    .q_stat (q_stat),
    .push   (q_push),
    .cmd    (q_push_cmd)
  );

  psd_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (q_push_cmd),
    .pop      (q_pop),
    .head_cmd (q_head_cmd),
    .q_stat   (q_stat)
  );

  psd_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .head_cmd (q_head_cmd),
    .q_stat   (q_stat),
    .pop      (q_pop),
    .out_ch   (out_ch)
  );

  // The parser never pushes into a full queue
  assert property (@(posedge clk) disable iff (!rst_n) q_push |-> !q_stat.full)
    else $error("command pushed into full queue");

  // The result stage never pops an empty queue
  assert property (@(posedge clk) disable iff (!rst_n) q_pop |-> !q_stat.empty)
    else $error("command popped from empty queue");

  // An offered header always carries legal dimensions
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.kind == KIND_HEADER) |->
      (out_ch.image_width != '0 && out_ch.image_height != '0 &&
       out_ch.image_width <= MAX_SIDE && out_ch.image_height <= MAX_SIDE))
    else $error("header result with illegal dimensions");

  // Error code is set exactly on error results
  assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> ((out_ch.kind == KIND_ERROR) == (out_ch.error_code != ERR_NONE)))
    else $error("error code does not match result kind");

endmodule : ppm_stream_decoder
`default_nettype wire

>>> sv/psd_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// psd_front
// Header parser and payload classifier. Takes one file byte per cycle while
// the queue has room, making at most one command (header, sample or error).
// ----------------------------------------------------------------------------
module psd_front (
  input  wire logic           clk,
  input  wire logic           rst_n,
  psd_in_if.sink              in_ch,
  psd_cfg_if.sink             cfg_ch,
  input  wire psd_pkg::q_stat_t q_stat,
  output logic                push,
  output psd_pkg::cmd_t       cmd
);
  import psd_pkg::*;

  typedef enum logic [9:0] {
    PH_MAGIC0  = 10'b00_0000_0001,
    PH_MAGIC1  = 10'b00_0000_0010,
    PH_SKIP_W  = 10'b00_0000_0100,
    PH_NUM_W   = 10'b00_0000_1000,
    PH_SKIP_H  = 10'b00_0001_0000,
    PH_NUM_H   = 10'b00_0010_0000,
    PH_SKIP_M  = 10'b00_0100_0000,
    PH_NUM_M   = 10'b00_1000_0000,
    PH_PAYLOAD = 10'b01_0000_0000,
    PH_DRAIN   = 10'b10_0000_0000
  } phase_t;

  phase_t              phase_r, phase_nxt;
  logic                comment_r, comment_nxt;
  logic [ACC_W-1:0]    acc_r, acc_nxt;
  logic [SIDE_W-1:0]   width_r, width_nxt;
  logic [SIDE_W-1:0]   height_r, height_nxt;
  logic                gray_r, gray_nxt;
  logic [1:0]          chan_r, chan_nxt;
  logic [AREA_W-1:0]   left_r, left_nxt;
  logic [AREA_W-1:0]   limit_r, limit_nxt;
  logic [AREA_W-1:0]   area_r;

  logic                accept;
  logic [7:0]          c;
  logic                is_digit;
  logic                is_space;
  logic [3:0]          dval;
  logic [PROD_W-1:0]   acc_prod;
  logic [SIDE_W-1:0]   acc_side;
  logic [AREA_W-1:0]   left_dec;
  logic                skip_en;
  phase_t              skip_to;
  logic                err_en;
  logic [2:0]          err_code;
  logic                done;

  assign accept   = in_ch.valid && in_ch.ready;
  assign in_ch.ready = !q_stat.full;
  assign cfg_ch.ready = 1'b1;
  assign c        = in_ch.data_byte;
  assign is_digit = (c >= CH_0) && (c <= CH_9);
  assign is_space = (c == CH_SP) || (c == CH_TAB) || (c == CH_LF) || (c == CH_CR);
  assign dval     = 4'(c - CH_0);
  assign acc_prod = PROD_W'({acc_r, 3'b000}) + PROD_W'({acc_r, 1'b0}) + PROD_W'(dval);
  assign acc_side = (acc_r > ACC_W'(MAX_SIDE)) ? SIDE_OVER : acc_r[SIDE_W-1:0];
  assign left_dec = (left_r != '0) ? left_r - AREA_W'(1) : '0;

  // Scale the area limit on a register write
  assign limit_nxt = (cfg_ch.valid && cfg_ch.ready)
                     ? AREA_W'(cfg_ch.max_megapixels) * MEGA : limit_r;

  // Parse one accepted byte
  always_comb begin
    phase_nxt   = phase_r;
    comment_nxt = comment_r;
    acc_nxt     = acc_r;
    width_nxt   = width_r;
    height_nxt  = height_r;
    gray_nxt    = gray_r;
    chan_nxt    = chan_r;
    left_nxt    = left_r;
    skip_en     = 1'b0;
    skip_to     = PH_NUM_W;
    err_en      = 1'b0;
    err_code    = ERR_NONE;
    done        = 1'b0;
    push        = 1'b0;
    cmd         = '0;
    cmd.op      = OP_SAMPLE;
    cmd.role    = ROLE_FINAL;

    if (accept) begin
      case (phase_r)
        PH_MAGIC0: begin
          if (c == CH_P) begin
            phase_nxt = PH_MAGIC1;
          end else begin
            err_en   = 1'b1;
            err_code = ERR_MAGIC;
          end
        end
        PH_MAGIC1: begin
          if (c == CH_5 || c == CH_6) begin
            gray_nxt  = (c == CH_5);
            phase_nxt = PH_SKIP_W;
          end else begin
            err_en   = 1'b1;
            err_code = ERR_MAGIC;
          end
        end
        PH_SKIP_W: begin
          skip_en = 1'b1;
          skip_to = PH_NUM_W;
        end
        PH_SKIP_H: begin
          skip_en = 1'b1;
          skip_to = PH_NUM_H;
        end
        PH_SKIP_M: begin
          skip_en = 1'b1;
          skip_to = PH_NUM_M;
        end
        PH_NUM_W, PH_NUM_H, PH_NUM_M: begin
          if (is_digit) begin
            if (acc_prod > NUM_LIMIT) begin
              err_en   = 1'b1;
              err_code = ERR_NUMBER;
            end else begin
              acc_nxt = acc_prod[ACC_W-1:0];
            end
          end else if (phase_r == PH_NUM_W) begin
            // Close the width; this byte opens the next skip
            width_nxt = acc_side;
            phase_nxt = PH_SKIP_H;
            skip_en   = 1'b1;
            skip_to   = PH_NUM_H;
          end else if (phase_r == PH_NUM_H) begin
            height_nxt = acc_side;
            phase_nxt  = PH_SKIP_M;
            skip_en    = 1'b1;
            skip_to    = PH_NUM_M;
          end else begin
            // Separator after maxval: check the header
            if (width_r == '0 || height_r == '0 || width_r > MAX_SIDE ||
                height_r > MAX_SIDE || acc_r != MAXVAL_REQ) begin
              err_en   = 1'b1;
              err_code = ERR_SIZE;
            end else if (area_r > limit_r) begin
              err_en   = 1'b1;
              err_code = ERR_AREA;
            end else begin
              left_nxt   = area_r;
              chan_nxt   = 2'd0;
              phase_nxt  = PH_PAYLOAD;
              push       = 1'b1;
              cmd.op     = OP_HEADER;
              cmd.width  = width_r;
              cmd.height = height_r;
              cmd.gray   = gray_r;
            end
          end
        end
        PH_PAYLOAD: begin
          push       = 1'b1;
          cmd.op     = OP_SAMPLE;
          cmd.sample = c;
          cmd.gray   = gray_r;
          if (!gray_r && chan_r == 2'd0) begin
            cmd.role = ROLE_RED;
            chan_nxt = 2'd1;
          end else if (!gray_r && chan_r == 2'd1) begin
            cmd.role = ROLE_GREEN;
            chan_nxt = 2'd2;
          end else begin
            cmd.role = ROLE_FINAL;
            chan_nxt = 2'd0;
            left_nxt = left_dec;
            done     = (left_dec == '0);
            cmd.last = done;
            if (done) begin
              phase_nxt = PH_DRAIN;
            end
          end
        end
        default: begin
          // Drain: drop bytes until end of file
        end
      endcase

      // Whitespace, comments, then the first digit of a number
      if (skip_en) begin
        if (comment_r) begin
          if (c == CH_LF) begin
            comment_nxt = 1'b0;
          end
        end else if (c == CH_HASH) begin
          comment_nxt = 1'b1;
        end else if (is_space) begin
          comment_nxt = 1'b0;
        end else if (is_digit) begin
          acc_nxt   = ACC_W'(dval);
          phase_nxt = skip_to;
        end else begin
          err_en   = 1'b1;
          err_code = ERR_NUMBER;
        end
      end

      if (err_en) begin
        push      = 1'b1;
        cmd       = '0;
        cmd.op    = OP_ERROR;
        cmd.role  = ROLE_FINAL;
        cmd.err   = err_code;
        phase_nxt = PH_DRAIN;
      end

      // End of file: flag truncation, then start over
      if (in_ch.end_of_file) begin
        if (phase_r != PH_DRAIN && !done) begin
          push     = 1'b1;
          cmd      = '0;
          cmd.op   = OP_ERROR;
          cmd.role = ROLE_FINAL;
          cmd.err  = ERR_TRUNCATED;
        end
        phase_nxt   = PH_MAGIC0;
        comment_nxt = 1'b0;
        acc_nxt     = '0;
        width_nxt   = '0;
        height_nxt  = '0;
        gray_nxt    = 1'b0;
        chan_nxt    = 2'd0;
        left_nxt    = '0;
      end
    end
  end

  // Hold parser state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_MAGIC0;
      comment_r <= 1'b0;
      acc_r     <= '0;
      width_r   <= '0;
      height_r  <= '0;
      gray_r    <= 1'b0;
      chan_r    <= 2'd0;
      left_r    <= '0;
      limit_r   <= AREA_W'(MPIX_RESET) * MEGA;
    end else begin
      phase_r   <= phase_nxt;
      comment_r <= comment_nxt;
      acc_r     <= acc_nxt;
      width_r   <= width_nxt;
      height_r  <= height_nxt;
      gray_r    <= gray_nxt;
      chan_r    <= chan_nxt;
      left_r    <= left_nxt;
      limit_r   <= limit_nxt;
    end
  end

  // Track the image area; settles before the maxval separator
  always_ff @(posedge clk) begin
    area_r <= AREA_W'(width_r) * AREA_W'(height_r);
  end

endmodule : psd_front
`default_nettype wire

>>> sv/psd_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// psd_queue
// Four-entry command queue between the parser and the result stage.
// ----------------------------------------------------------------------------
module psd_queue (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  wire psd_pkg::cmd_t  push_cmd,
  input  wire logic           pop,
  output psd_pkg::cmd_t       head_cmd,
  output psd_pkg::q_stat_t    q_stat
);
  import psd_pkg::*;

  cmd_t               entry_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [Q_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [Q_PTR_W:0]   count_r, count_nxt;
  logic               do_push;
  logic               do_pop;

  assign q_stat.empty = (count_r == '0);
  assign q_stat.full  = (count_r == (Q_PTR_W+1)'(Q_DEPTH));
  assign do_push      = push && !q_stat.full;
  assign do_pop       = pop && !q_stat.empty;
  assign head_cmd     = entry_r[rd_ptr_r];

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + Q_PTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + Q_PTR_W'(1) : rd_ptr_r;
    count_nxt  = count_r + (Q_PTR_W+1)'(do_push) - (Q_PTR_W+1)'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store the pushed command
  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule : psd_queue
`default_nettype wire

>>> sv/psd_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// psd_back
// Result stage. Pops commands, collects red and green samples, builds BGR
// pixels and drives the registered result channel.
// ----------------------------------------------------------------------------
module psd_back (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire psd_pkg::cmd_t    head_cmd,
  input  wire psd_pkg::q_stat_t q_stat,
  output logic                  pop,
  psd_out_if.source             out_ch
);
  import psd_pkg::*;

  logic               valid_r, valid_nxt;
  logic [7:0]         held_red_r, held_green_r;
  logic [1:0]         kind_r;
  logic [SIDE_W-1:0]  width_r, height_r;
  logic               gray_r;
  logic [7:0]         blue_r, green_r, red_r;
  logic               last_r;
  logic [2:0]         err_r;
  logic               can_take;
  logic               emit;

  assign can_take = !valid_r || out_ch.ready;
  assign pop      = can_take && !q_stat.empty;
  assign emit     = pop && !(head_cmd.op == OP_SAMPLE && head_cmd.role != ROLE_FINAL);

  // Output register valid: load on a result, drop on a transfer
  always_comb begin
    if (emit) begin
      valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      valid_nxt = 1'b0;
    end else begin
      valid_nxt = valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Hold color samples and load the result fields
  always_ff @(posedge clk) begin
    if (pop && head_cmd.op == OP_SAMPLE && head_cmd.role == ROLE_RED) begin
      held_red_r <= head_cmd.sample;
    end
    if (pop && head_cmd.op == OP_SAMPLE && head_cmd.role == ROLE_GREEN) begin
      held_green_r <= head_cmd.sample;
    end
    if (emit) begin
      case (head_cmd.op)
        OP_HEADER: begin
          kind_r   <= KIND_HEADER;
          width_r  <= head_cmd.width;
          height_r <= head_cmd.height;
          gray_r   <= head_cmd.gray;
          blue_r   <= '0;
          green_r  <= '0;
          red_r    <= '0;
          last_r   <= 1'b0;
          err_r    <= ERR_NONE;
        end
        OP_SAMPLE: begin
          kind_r   <= KIND_PIXEL;
          width_r  <= '0;
          height_r <= '0;
          gray_r   <= 1'b0;
          blue_r   <= head_cmd.sample;
          green_r  <= head_cmd.gray ? head_cmd.sample : held_green_r;
          red_r    <= head_cmd.gray ? head_cmd.sample : held_red_r;
          last_r   <= head_cmd.last;
          err_r    <= ERR_NONE;
        end
        default: begin
          kind_r   <= KIND_ERROR;
          width_r  <= '0;
          height_r <= '0;
          gray_r   <= 1'b0;
          blue_r   <= '0;
          green_r  <= '0;
          red_r    <= '0;
          last_r   <= 1'b0;
          err_r    <= head_cmd.err;
        end
      endcase
    end
  end

  assign out_ch.valid        = valid_r;
  assign out_ch.kind         = kind_r;
  assign out_ch.image_width  = width_r;
  assign out_ch.image_height = height_r;
  assign out_ch.is_gray      = gray_r;
  assign out_ch.blue         = blue_r;
  assign out_ch.green        = green_r;
  assign out_ch.red          = red_r;
  assign out_ch.last_pixel   = last_r;
  assign out_ch.error_code   = err_r;

endmodule : psd_back
`default_nettype wire

>>> test/psd_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psd_checker
// Follows the decoder's byte, result and area limit transfers. It keeps its
// own copy of the parser state, works out the result that each byte should
// give, and compares every delivered result with the oldest one still due.
// ----------------------------------------------------------------------------
module psd_checker
  import psd_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  psd_in_if    in_ch,
  psd_out_if   out_ch,
  psd_cfg_if   cfg_ch,
  output int   fail_count,
  output int   pending
);

  localparam int SHOW_LIMIT = 10;

  typedef enum logic [3:0] {
    PS_MAGIC0,
    PS_MAGIC1,
    PS_SKIP_W,
    PS_NUM_W,
    PS_SKIP_H,
    PS_NUM_H,
    PS_SKIP_M,
    PS_NUM_M,
    PS_PAYLOAD,
    PS_DRAIN
  } parse_st_t;

  typedef struct packed {
    logic [1:0]        kind;
    logic [SIDE_W-1:0] width;
    logic [SIDE_W-1:0] height;
    logic              gray;
    logic [7:0]        blue;
    logic [7:0]        green;
    logic [7:0]        red;
    logic              last;
    logic [2:0]        err;
  } decoded_t;

  // Parser copy
  parse_st_t         parse_st;
  logic              in_cmt;
  logic [ACC_W-1:0]  acc;
  logic [SIDE_W-1:0] wid;
  logic [SIDE_W-1:0] hgt;
  logic              gray_img;
  logic [1:0]        chan;
  logic [7:0]        held_r;
  logic [7:0]        held_g;
  logic [AREA_W-1:0] px_left;
  logic [MPIX_W-1:0] area_limit;

  // Result of the byte being decoded
  decoded_t          step_res;
  bit                step_hit;

  decoded_t          due_results[$];

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  function automatic bit is_dec(input logic [7:0] c);
    return c >= CH_0 && c <= CH_9;
  endfunction

  function automatic logic [SIDE_W-1:0] clip_side(input logic [ACC_W-1:0] v);
    return (v > MAX_SIDE) ? SIDE_OVER : v[SIDE_W-1:0];
  endfunction

  function void restart_parse();
    parse_st = PS_MAGIC0;
    in_cmt   = 1'b0;
    acc      = '0;
    wid      = '0;
    hgt      = '0;
    gray_img = 1'b0;
    chan     = '0;
    held_r   = '0;
    held_g   = '0;
    px_left  = '0;
  endfunction

  function void raise_error(input logic [2:0] code);
    step_res      = '0;
    step_res.kind = KIND_ERROR;
    step_res.err  = code;
    step_hit      = 1'b1;
    parse_st      = PS_DRAIN;
  endfunction

  // Whitespace and comments, then the first digit of a number
  function void skip_char(input logic [7:0] c, input parse_st_t num_st);
    if (in_cmt) begin
      if (c == CH_LF) in_cmt = 1'b0;
    end else if (c == CH_HASH) begin
      in_cmt = 1'b1;
    end else if (!(c == CH_SP || c == CH_TAB || c == CH_LF || c == CH_CR)) begin
      if (is_dec(c)) begin
        acc      = c - CH_0;
        parse_st = num_st;
      end else begin
        raise_error(ERR_NUMBER);
      end
    end
  endfunction

  function void decode_byte(input logic [7:0] c, input logic eof);
    logic [31:0] grown;
    logic        was_drain;
    logic        done;
    was_drain = (parse_st == PS_DRAIN);
    done      = 1'b0;
    step_hit  = 1'b0;
    step_res  = '0;
    case (parse_st)
      PS_MAGIC0: begin
        if (c == CH_P) parse_st = PS_MAGIC1;
        else raise_error(ERR_MAGIC);
      end
      PS_MAGIC1: begin
        if (c == CH_5 || c == CH_6) begin
          gray_img = (c == CH_5);
          parse_st = PS_SKIP_W;
        end else begin
          raise_error(ERR_MAGIC);
        end
      end
      PS_SKIP_W: skip_char(c, PS_NUM_W);
      PS_SKIP_H: skip_char(c, PS_NUM_H);
      PS_SKIP_M: skip_char(c, PS_NUM_M);
      PS_NUM_W, PS_NUM_H, PS_NUM_M: begin
        if (is_dec(c)) begin
          grown = 32'(acc) * 32'd10 + (32'(c) - 32'(CH_0));
          if (grown > 32'(NUM_LIMIT)) raise_error(ERR_NUMBER);
          else acc = grown[ACC_W-1:0];
        end else if (parse_st == PS_NUM_W) begin
          wid      = clip_side(acc);
          parse_st = PS_SKIP_H;
          skip_char(c, PS_NUM_H);
        end else if (parse_st == PS_NUM_H) begin
          hgt      = clip_side(acc);
          parse_st = PS_SKIP_M;
          skip_char(c, PS_NUM_M);
        end else if (wid == '0 || hgt == '0 || wid > MAX_SIDE || hgt > MAX_SIDE ||
                     acc != MAXVAL_REQ) begin
          // c is the separator after maxval
          raise_error(ERR_SIZE);
        end else if (64'(wid) * 64'(hgt) > 64'(area_limit) * 64'(MEGA)) begin
          raise_error(ERR_AREA);
        end else begin
          px_left         = wid * hgt;
          chan            = '0;
          parse_st        = PS_PAYLOAD;
          step_hit        = 1'b1;
          step_res.kind   = KIND_HEADER;
          step_res.width  = wid;
          step_res.height = hgt;
          step_res.gray   = gray_img;
        end
      end
      PS_PAYLOAD: begin
        if (!gray_img && chan == 2'd0) begin
          held_r = c;
          chan   = 2'd1;
        end else if (!gray_img && chan == 2'd1) begin
          held_g = c;
          chan   = 2'd2;
        end else begin
          chan = 2'd0;
          if (px_left != '0) px_left = px_left - 1'b1;
          if (px_left == '0) begin
            parse_st = PS_DRAIN;
            done     = 1'b1;
          end
          step_hit       = 1'b1;
          step_res.kind  = KIND_PIXEL;
          step_res.blue  = c;
          step_res.green = gray_img ? c : held_g;
          step_res.red   = gray_img ? c : held_r;
          step_res.last  = done;
        end
      end
      default: ;
    endcase
    // An early end of file overrides whatever this byte gave
    if (eof) begin
      if (!was_drain && !done) begin
        step_res      = '0;
        step_res.kind = KIND_ERROR;
        step_res.err  = ERR_TRUNCATED;
        step_hit      = 1'b1;
      end
      restart_parse();
    end
  endfunction

  function automatic string show(input decoded_t r);
    return $sformatf("kind=%0d w=%0d h=%0d gray=%0d b=%02h g=%02h r=%02h last=%0d err=%0d",
                     r.kind, r.width, r.height, r.gray, r.blue, r.green, r.red,
                     r.last, r.err);
  endfunction

  function void note_failure(input string msg);
    fail_count++;
    if (fail_count <= SHOW_LIMIT) $display("[%0t] %s", $time, msg);
  endfunction

  // Compare delivered results, then apply register and byte transfers
  always @(posedge clk) begin : watch
    decoded_t got;
    decoded_t want;
    if (!rst_n) begin
      restart_parse();
      area_limit = MPIX_RESET;
      due_results.delete();
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        got.kind   = out_ch.kind;
        got.width  = out_ch.image_width;
        got.height = out_ch.image_height;
        got.gray   = out_ch.is_gray;
        got.blue   = out_ch.blue;
        got.green  = out_ch.green;
        got.red    = out_ch.red;
        got.last   = out_ch.last_pixel;
        got.err    = out_ch.error_code;
        if (due_results.size() == 0) begin
          note_failure($sformatf("result with nothing due: %s", show(got)));
        end else begin
          want = due_results.pop_front();
          if (got !== want)
            note_failure($sformatf("result mismatch: expected %s, got %s",
                                   show(want), show(got)));
        end
      end
      if (cfg_ch.valid && cfg_ch.ready) area_limit = cfg_ch.max_megapixels;
      if (in_ch.valid && in_ch.ready) begin
        decode_byte(in_ch.data_byte, in_ch.end_of_file);
        if (step_hit) due_results.push_back(step_res);
      end
    end
    pending = due_results.size();
  end

endmodule : psd_checker

>>> test/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stimulus for the PGM/PPM stream decoder: a few hand-made files, then
// random files, mostly well-formed headers with random comments, spacing and
// pixel data, mixed with corrupted, cut and padded files and plain noise.
// The area limit is changed between stretches, the handshakes idle at random
// and the result side holds off once for a long stretch.
// ----------------------------------------------------------------------------
module tb;
  import psd_pkg::*;

  localparam int HALF_PERIOD    = 10;
  localparam int RESET_CYCLES   = 11;
  localparam int SETTLE_CYCLES  = 10;
  localparam int HOLD_CYCLES    = 300;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int STRETCHES      = 6;
  localparam int STRETCH_BYTES  = 100;

  logic       clk;
  logic       rst_n;
  logic [7:0] file_buf[$];
  int         bytes_sent    = 0;
  int         src_idle_pct  = 0;
  int         sink_idle_pct = 0;
  logic       hold_off;
  logic       pressure_go   = 1'b0;
  int         quiet_cycles  = 0;
  int         fail_count;
  int         pending;

  psd_in_if  in_ch ();
  psd_out_if out_ch ();
  psd_cfg_if cfg_ch ();

  ppm_stream_decoder dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  psd_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .cfg_ch     (cfg_ch),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial clk = 1'b0;
  always #HALF_PERIOD clk = ~clk;

  // Result side: random stalls, plus the long hold-off
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      out_ch.ready <= !hold_off && ($urandom_range(99) >= sink_idle_pct);
    end
  end

  initial begin
    hold_off = 1'b0;
    wait (pressure_go);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off <= 1'b0;
  end

  // End the run if no transfer happens for too long
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic push_byte(input logic [7:0] b, input logic eof);
    while ($urandom_range(99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.data_byte   <= b;
    in_ch.end_of_file <= eof;
    do @(posedge clk); while (!in_ch.ready);
    bytes_sent++;
  endtask

  task automatic send_file();
    for (int i = 0; i < file_buf.size(); i++) push_byte(file_buf[i], i == file_buf.size() - 1);
  endtask

  // Write the area limit once every due result is in and the block has settled
  task automatic write_area_limit(input logic [MPIX_W-1:0] lim);
    @(negedge clk);
    wait (pending == 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_ch.valid          <= 1'b1;
    cfg_ch.max_megapixels <= lim;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic load_text(input string s);
    file_buf.delete();
    for (int i = 0; i < s.len(); i++) file_buf.push_back(s[i]);
  endtask

  task automatic add_number(input int unsigned v);
    string digits;
    digits = $sformatf("%0d", v);
    if ($urandom_range(7) == 0) file_buf.push_back(CH_0);
    for (int i = 0; i < digits.len(); i++) file_buf.push_back(digits[i]);
  endtask

  // Whitespace run with the odd comment
  task automatic add_gap(input int unsigned min_len);
    int unsigned n;
    logic [7:0]  c;
    n = $urandom_range(min_len + 2, min_len);
    repeat (n) begin
      if ($urandom_range(3) == 0) begin
        file_buf.push_back(CH_HASH);
        repeat ($urandom_range(4)) begin
          c = 8'($urandom_range(255));
          file_buf.push_back(c == CH_LF ? CH_SP : c);
        end
        file_buf.push_back(CH_LF);
      end else begin
        case ($urandom_range(3))
          0:       file_buf.push_back(CH_SP);
          1:       file_buf.push_back(CH_TAB);
          2:       file_buf.push_back(CH_LF);
          default: file_buf.push_back(CH_CR);
        endcase
      end
    end
  endtask

  task automatic build_image(input bit gray, input int unsigned w, input int unsigned h,
                             input int unsigned maxval, input int unsigned n_pay);
    logic [7:0] sep;
    file_buf.delete();
    file_buf.push_back(CH_P);
    file_buf.push_back(gray ? CH_5 : CH_6);
    add_gap(0);
    add_number(w);
    add_gap(1);
    add_number(h);
    add_gap(1);
    add_number(maxval);
    // any non-digit ends maxval and is consumed
    do sep = 8'($urandom_range(255)); while (sep >= CH_0 && sep <= CH_9);
    file_buf.push_back(sep);
    repeat (n_pay) file_buf.push_back(8'($urandom_range(255)));
  endtask

  function automatic int unsigned pick_side();
    case ($urandom_range(11))
      0:       return 0;
      1:       return 1000;
      2:       return 1001;
      3:       return 16000;
      4:       return 16384;
      5:       return 16385;
      6:       return 99999;
      7:       return 100000;
      8:       return 100001;
      9:       return 987654;
      default: return $urandom_range(16384, 1);
    endcase
  endfunction

  function automatic int unsigned pick_maxval();
    if ($urandom_range(9) != 0) return 255;
    case ($urandom_range(3))
      0:       return 0;
      1:       return 254;
      2:       return 256;
      default: return 65535;
    endcase
  endfunction

  task automatic build_file();
    int unsigned sel;
    int unsigned w;
    int unsigned h;
    int unsigned n;
    bit          gray;
    sel = $urandom_range(99);
    // plain noise, sometimes with a good first magic byte
    if (sel < 10) begin
      file_buf.delete();
      if ($urandom_range(1)) file_buf.push_back(CH_P);
      repeat ($urandom_range(6, 1)) file_buf.push_back(8'($urandom_range(255)));
      return;
    end
    gray = $urandom_range(1);
    if (sel < 22) begin
      // large or out-of-range sides, cut short in the payload
      w = pick_side();
      h = pick_side();
      n = $urandom_range(4);
    end else begin
      w = $urandom_range(4, 1);
      h = $urandom_range(4, 1);
      n = w * h * (gray ? 1 : 3);
    end
    build_image(gray, w, h, pick_maxval(), n);
    sel = $urandom_range(99);
    if (sel < 12) begin
      file_buf[$urandom_range(file_buf.size() - 1)] = 8'($urandom_range(255));
    end else if (sel < 27) begin
      n = $urandom_range(file_buf.size(), 1);
      while (file_buf.size() > n) void'(file_buf.pop_back());
    end else if (sel < 42) begin
      repeat ($urandom_range(4, 1)) file_buf.push_back(8'($urandom_range(255)));
    end
  endtask

  initial begin
    int                stretch;
    int                target;
    logic [MPIX_W-1:0] lim;
    in_ch.valid           = 1'b0;
    in_ch.data_byte       = '0;
    in_ch.end_of_file     = 1'b0;
    cfg_ch.valid          = 1'b0;
    cfg_ch.max_megapixels = '0;
    rst_n                 = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    for (stretch = 0; stretch < STRETCHES; stretch++) begin
      case (stretch)
        0:       lim = 9'd1;
        1:       lim = 9'd268;
        2:       lim = 9'd0;
        3:       lim = 9'd511;
        4:       lim = MPIX_RESET;
        default: lim = 9'($urandom_range(267, 2));
      endcase
      write_area_limit(lim);

      // idle pattern changes every two stretches
      case (stretch / 2)
        0: begin
          src_idle_pct  = 11;
          sink_idle_pct <= 46;
        end
        1: begin
          src_idle_pct  = 46;
          sink_idle_pct <= 11;
        end
        default: begin
          src_idle_pct  = 0;
          sink_idle_pct <= 0;
        end
      endcase

      if (stretch == 0) begin
        // smallest gray image, bad magic, color image cut in its first pixel
        load_text("P5 1 1 255\n");
        file_buf.push_back(8'hFF);
        send_file();
        load_text("XZ");
        send_file();
        load_text("P6\t2 1 255\r");
        file_buf.push_back(8'h00);
        file_buf.push_back(8'h80);
        send_file();
      end

      if (stretch == 4) begin
        // fill the block while the result side holds off
        pressure_go <= 1'b1;
        build_image(1'b0, 4, 4, 255, 48);
        send_file();
      end

      target = bytes_sent + STRETCH_BYTES;
      while (bytes_sent < target) begin
        build_file();
        send_file();
      end
      in_ch.valid <= 1'b0;
    end

    @(negedge clk);
    wait (pending == 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule : tb
